FILE: src/ltc_pkg.sv
// Package for the lexical token classifier: token kinds, queue entry types,
// keyword tables and byte class functions. Depends on nothing else.
package ltc_pkg;

    localparam int unsigned MAX_TOKEN_LENGTH = 255;
    localparam int unsigned LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int unsigned NUM_KEYWORDS     = 10;
    localparam int unsigned KW_TEXT_BYTES    = 6;
    localparam int unsigned QUEUE_DEPTH      = 4;
    localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [2:0] {
        KIND_KEYWORD  = 3'd0,
        KIND_NUMBER   = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_OPERATOR = 3'd3,
        KIND_SYMBOL   = 3'd4
    } kind_t;

    typedef struct packed {
        logic        has_word;
        kind_t       word_kind;
        logic [7:0]  word_len;
        logic [3:0]  kw_index;
        logic        has_sym;
        kind_t       sym_kind;
        logic [7:0]  sym_char;
        logic        eol;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

    function automatic logic [8*KW_TEXT_BYTES-1:0] kw_text(input logic [3:0] k);
        logic [8*KW_TEXT_BYTES-1:0] t;
        case (k)
            4'd0:    t = {"int", 24'd0};
            4'd1:    t = {"float", 8'd0};
            4'd2:    t = {"if", 32'd0};
            4'd3:    t = {"else", 16'd0};
            4'd4:    t = {"while", 8'd0};
            4'd5:    t = "return";
            4'd6:    t = {"for", 24'd0};
            4'd7:    t = {"char", 16'd0};
            4'd8:    t = "double";
            4'd9:    t = {"void", 16'd0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        logic [2:0] n;
        case (k)
            4'd0:    n = 3'd3;
            4'd1:    n = 3'd5;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd4;
            4'd4:    n = 3'd5;
            4'd5:    n = 3'd6;
            4'd6:    n = 3'd3;
            4'd7:    n = 3'd4;
            4'd8:    n = 3'd6;
            4'd9:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [8*KW_TEXT_BYTES-1:0] t;
        t = kw_text(k);
        if (p >= 3'(KW_TEXT_BYTES)) begin
            return 8'd0;
        end
        return t[8*KW_TEXT_BYTES-1 - 8*p -: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c inside {"+", "-", "*", "/", "=", "%", "<", ">", "!"};
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c inside {"(", ")", ";", "{", "}", ","};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

endpackage

FILE: src/ltc_if.sv
// Channel interfaces for the lexical token classifier: the byte input
// channel and the token output channel. No dependencies.
interface ltc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

interface ltc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [7:0] symbol_char;
    logic [7:0] token_length;
    logic [3:0] keyword_index;
    logic       last_of_run;
    logic       line_end;

    modport source (output valid, output token_kind, output symbol_char,
                    output token_length, output keyword_index, output last_of_run,
                    output line_end, input ready);
    modport sink (input valid, input token_kind, input symbol_char,
                  input token_length, input keyword_index, input last_of_run,
                  input line_end, output ready);
endinterface

FILE: src/lexical_token_classifier.sv
// Lexical token classifier top level: front end, run queue and back end.
// Depends on ltc_pkg, ltc_if, ltc_front, ltc_queue and ltc_back.
//
// The block takes one source byte per clock cycle on char_in while the run
// queue is not full and reports keyword, number, identifier, operator and
// symbol tokens on token_out. A byte that gives a result is written into the
// queue, and its first result is later loaded from the queue head into the
// output register. A byte that both ends a word and is an operator or symbol
// causes two results, which leave the block one after the other through the
// single output register; a four-entry queue between the front and back ends
// absorbs these bursts and any stall on token_out, so the input keeps accepting
// one byte per cycle as long as the long-run output rate keeps up. Keywords are
// recognized with a running candidate mask, so no token text is stored.
module lexical_token_classifier (
    input  logic       clk,
    input  logic       rst_n,
    ltc_in_if.sink     char_in,
    ltc_out_if.source  token_out
);

    logic              push;
    logic              full;
    logic              pop;
    ltc_pkg::entry_t   push_entry;
    ltc_pkg::q_head_t  head;

    ltc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    ltc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head)
    );

    ltc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .token_out (token_out)
    );

endmodule

FILE: src/ltc_front.sv
// Front end: accepts bytes, tracks the pending word and classifies it.
// Depends on ltc_pkg and ltc_in_if.
module ltc_front (
    input  logic              clk,
    input  logic              rst_n,
    ltc_in_if.sink            char_in,
    input  logic              full,
    output logic              push,
    output ltc_pkg::entry_t   push_entry
);

    logic [ltc_pkg::NUM_KEYWORDS-1:0] cand_reg, cand_next;
    ltc_pkg::len_t                    len_reg, len_next;
    logic                             digits_reg, digits_next;

    always_comb
    begin
        logic [7:0]                       c;
        logic                             eol;
        logic                             accept;
        logic                             sp, op, sy, other;
        logic [ltc_pkg::NUM_KEYWORDS-1:0] mask, keep, fl_cand;
        ltc_pkg::len_t                    ext_len, fl_len;
        logic                             ext_digits, fl_digits, do_flush;
        ltc_pkg::kind_t                   wkind;
        logic [3:0]                       kwi;

        c      = char_in.char_code;
        eol    = char_in.end_of_line;
        accept = char_in.valid && !full;
        sp     = ltc_pkg::is_space(c);
        op     = ltc_pkg::is_operator(c);
        sy     = ltc_pkg::is_symbol(c);
        other  = !sp && !op && !sy;

        mask = (len_reg == '0) ? '1 : cand_reg;
        for (int k = 0; k < ltc_pkg::NUM_KEYWORDS; k++) begin
            keep[k] = mask[k]
                && (len_reg < ltc_pkg::LEN_W'(ltc_pkg::kw_len(4'(k))))
                && (ltc_pkg::kw_char(4'(k), len_reg[2:0]) == c);
        end
        ext_len    = (32'(len_reg) < ltc_pkg::MAX_TOKEN_LENGTH) ? len_reg + 1'b1 : len_reg;
        ext_digits = digits_reg && ltc_pkg::is_digit(c);

        if (other) begin
            fl_cand   = keep;
            fl_len    = ext_len;
            fl_digits = ext_digits;
            do_flush  = eol;
        end
        else begin
            fl_cand   = cand_reg;
            fl_len    = len_reg;
            fl_digits = digits_reg;
            do_flush  = (len_reg != '0);
        end

        wkind = fl_digits ? ltc_pkg::KIND_NUMBER : ltc_pkg::KIND_IDENT;
        kwi   = 4'd0;
        for (int k = ltc_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (fl_cand[k] && (fl_len == ltc_pkg::LEN_W'(ltc_pkg::kw_len(4'(k))))) begin
                wkind = ltc_pkg::KIND_KEYWORD;
                kwi   = 4'(k);
            end
        end

        push_entry.has_word  = do_flush;
        push_entry.word_kind = wkind;
        push_entry.word_len  = (32'(fl_len) > 32'd255) ? 8'hFF : 8'(fl_len);
        push_entry.kw_index  = (wkind == ltc_pkg::KIND_KEYWORD) ? kwi : 4'd0;
        push_entry.has_sym   = op || sy;
        push_entry.sym_kind  = op ? ltc_pkg::KIND_OPERATOR : ltc_pkg::KIND_SYMBOL;
        push_entry.sym_char  = c;
        push_entry.eol       = eol;

        char_in.ready = !full;
        push          = accept && (do_flush || op || sy);

        cand_next   = cand_reg;
        len_next    = len_reg;
        digits_next = digits_reg;
        if (accept) begin
            if (other && !eol) begin
                cand_next   = keep;
                len_next    = ext_len;
                digits_next = ext_digits;
            end
            else begin
                cand_next   = '0;
                len_next    = '0;
                digits_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cand_reg   <= '0;
            len_reg    <= '0;
            digits_reg <= 1'b1;
        end
        else begin
            cand_reg   <= cand_next;
            len_reg    <= len_next;
            digits_reg <= digits_next;
        end
    end

endmodule

FILE: src/ltc_queue.sv
// Short queue of classified runs between the front and back ends.
// Depends on ltc_pkg.
module ltc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ltc_pkg::entry_t   push_entry,
    output logic              full,
    input  logic              pop,
    output ltc_pkg::q_head_t  head
);

    ltc_pkg::entry_t                  mem [ltc_pkg::QUEUE_DEPTH];
    logic [ltc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ltc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ltc_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    always_comb
    begin
        full       = (count_reg == ltc_pkg::QCNT_W'(ltc_pkg::QUEUE_DEPTH));
        head.valid = (count_reg != '0);
        head.entry = mem[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head.valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ltc_pkg::QPTR_W'(ltc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ltc_pkg::QPTR_W'(ltc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + ltc_pkg::QCNT_W'(do_push) - ltc_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/ltc_back.sv
// Back end: splits each queued run into word and symbol results and
// holds them in the output register. Depends on ltc_pkg and ltc_out_if.
module ltc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ltc_pkg::q_head_t  head,
    output logic              pop,
    ltc_out_if.source         token_out
);

    logic           valid_reg, valid_next;
    logic           word_done_reg, word_done_next;
    ltc_pkg::kind_t kind_reg, kind_next;
    logic [7:0]     sym_reg, sym_next;
    logic [7:0]     len_reg, len_next;
    logic [3:0]     kw_reg, kw_next;
    logic           last_reg, last_next;
    logic           line_end_reg, line_end_next;

    always_comb
    begin
        logic load;
        logic emit_word;
        logic last;

        load      = !valid_reg || token_out.ready;
        emit_word = head.entry.has_word && !word_done_reg;
        last      = emit_word ? !head.entry.has_sym : 1'b1;

        valid_next     = valid_reg;
        word_done_next = word_done_reg;
        kind_next      = kind_reg;
        sym_next       = sym_reg;
        len_next       = len_reg;
        kw_next        = kw_reg;
        last_next      = last_reg;
        line_end_next  = line_end_reg;
        pop            = 1'b0;

        if (load) begin
            valid_next = head.valid;
            if (head.valid) begin
                if (emit_word) begin
                    kind_next = head.entry.word_kind;
                    sym_next  = 8'd0;
                    len_next  = head.entry.word_len;
                    kw_next   = head.entry.kw_index;
                end
                else begin
                    kind_next = head.entry.sym_kind;
                    sym_next  = head.entry.sym_char;
                    len_next  = 8'd1;
                    kw_next   = 4'd0;
                end
                last_next      = last;
                line_end_next  = last && head.entry.eol;
                pop            = last;
                word_done_next = !last;
            end
        end

        token_out.valid         = valid_reg;
        token_out.token_kind    = kind_reg;
        token_out.symbol_char   = sym_reg;
        token_out.token_length  = len_reg;
        token_out.keyword_index = kw_reg;
        token_out.last_of_run   = last_reg;
        token_out.line_end      = line_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg     <= 1'b0;
            word_done_reg <= 1'b0;
        end
        else begin
            valid_reg     <= valid_next;
            word_done_reg <= word_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sym_reg      <= sym_next;
        len_reg      <= len_next;
        kw_reg       <= kw_next;
        last_reg     <= last_next;
        line_end_reg <= line_end_next;
    end

    // A half-emitted run must still be at the head and must still owe its symbol.
    a_word_done_head: assert property (@(posedge clk) disable iff (!rst_n)
        word_done_reg |-> head.valid && head.entry.has_word && head.entry.has_sym)
        else $error("word half of a run sent but head does not hold its symbol");

    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && line_end_reg |-> last_reg)
        else $error("line end flagged on a result that is not last of its run");

    a_symbol_fields: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (kind_reg == ltc_pkg::KIND_OPERATOR || kind_reg == ltc_pkg::KIND_SYMBOL)
        |-> len_reg == 8'd1 && kw_reg == 4'd0 && last_reg)
        else $error("operator or symbol result with bad length, index or run flag");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !word_done_reg)
        else $error("run removed from queue while its word half is still marked");

endmodule
